[design/swemm_pkg.sv]
// ----------------------------------------------------------------------------
// swemm_pkg
// operation and status codes for the bounded stack with min/max extract
// ----------------------------------------------------------------------------
package swemm_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 4;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXT_MIN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXT_MAX = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RSVD  = 2'd3;

endpackage

[design/stack_with_extract_min_max_core.sv]
// sequence: push and any error go from accept to the response state, pop reads the top
// entry in its own state first, extract makes one pass over the memory to find the extreme
// and one pass to compact the survivors (one read port and one write port)
// throughput: one item at a time; a new item is taken once the result is loaded
// reset clears the fill count and the output valid; memory contents stay undefined
// ----------------------------------------------------------------------------
// stack_with_extract_min_max_core
// bounded stack of signed words with pop, push, extract minimum and maximum
// ----------------------------------------------------------------------------
module stack_with_extract_min_max_core #(
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [swemm_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [swemm_pkg::DATA_W-1:0]     i_value,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [swemm_pkg::DATA_W-1:0]     o_result_value,
    output logic [swemm_pkg::STATUS_W-1:0]          o_status,
    output logic [swemm_pkg::COUNT_W-1:0]           o_count
);
    import swemm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_COMPACT,
        S_RESP
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_rd_idx;
    logic [CW-1:0]              r_kept;
    logic                       r_dv;
    logic                       r_first;
    logic [MODE_W-1:0]          r_mode;
    logic signed [DATA_W-1:0]   r_best;
    logic signed [DATA_W-1:0]   r_res;
    logic [STATUS_W-1:0]        r_stat;
    logic                       r_out_valid;
    logic signed [DATA_W-1:0]   r_out_value;
    logic [STATUS_W-1:0]        r_out_status;
    logic [CW-1:0]              r_out_count;

    logic signed [DATA_W-1:0]   mem [DEPTH];
    logic signed [DATA_W-1:0]   r_rd_data;

    logic                       full;
    logic [CW-1:0]              cnt_m1;
    logic                       scan_more;
    logic                       better;
    logic                       keep;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic signed [DATA_W-1:0]   mem_wr_data;
    logic                       out_free;

    assign full      = (r_count == CW'(DEPTH));
    assign cnt_m1    = r_count - 1'b1;
    assign scan_more = (r_rd_idx < r_count);
    assign better    = (r_mode == MODE_EXT_MAX) ? (r_rd_data > r_best) : (r_rd_data < r_best);
    assign keep      = r_dv && (r_rd_data != r_best);
    assign out_free  = !r_out_valid || !i_stall;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_count        = COUNT_W'(r_out_count);

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_idx[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_kept[AW-1:0];
        mem_wr_data = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_mode == MODE_PUSH && !full) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_count[AW-1:0];
                    mem_wr_data = i_value;
                end
                if (i_valid && i_mode == MODE_POP && r_count != '0) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cnt_m1[AW-1:0];
                end
            end
            S_SCAN: begin
                mem_rd_en = scan_more;
            end
            S_COMPACT: begin
                // writes trail the reads, so the write slot never meets the read slot
                mem_rd_en = scan_more;
                mem_wr_en = keep;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (r_out_valid && !i_stall && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode   <= i_mode;
                        r_res    <= '0;
                        r_rd_idx <= '0;
                        r_dv     <= 1'b0;
                        r_first  <= 1'b1;
                        if (i_mode == MODE_PUSH) begin
                            if (full) begin
                                r_stat <= ST_FULL;
                            end else begin
                                r_stat  <= ST_OK;
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_RESP;
                        end else if (r_count == '0) begin
                            r_stat  <= ST_EMPTY;
                            r_state <= S_RESP;
                        end else if (i_mode == MODE_POP) begin
                            r_stat  <= ST_OK;
                            r_count <= cnt_m1;
                            r_state <= S_POP;
                        end else begin
                            r_stat  <= ST_OK;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_POP: begin
                    r_res   <= r_rd_data;
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    if (scan_more) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    r_dv <= scan_more;
                    if (r_dv) begin
                        r_first <= 1'b0;
                        if (r_first || better) begin
                            r_best <= r_rd_data;
                        end
                    end
                    if (!r_dv && !scan_more) begin
                        r_rd_idx <= '0;
                        r_kept   <= '0;
                        r_state  <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    if (scan_more) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    r_dv <= scan_more;
                    if (keep) begin
                        r_kept <= r_kept + 1'b1;
                    end
                    if (!r_dv && !scan_more) begin
                        r_count <= r_kept;
                        r_res   <= r_best;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res;
                        r_out_status <= r_stat;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPACT |-> r_kept <= r_rd_idx)
        else $error("compaction write passed the read pointer");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> r_out_count == CW'(DEPTH))
        else $error("full status with stack not full");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_result_value == '0 && r_out_count == '0)
        else $error("empty status with nonzero value or count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != ST_RSVD)
        else $error("reserved status code on output");

    a_extract_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPACT && !r_dv && !scan_more |=> r_count < $past(r_count))
        else $error("extract did not remove an entry");

endmodule

[tb/stack_with_extract_min_max_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_extract_min_max_core_tb
// self-checking bench for the bounded stack with minimum and maximum extract.
// a short table of hand-picked operations (empty and full errors, signed
// extremes, duplicate extremes) is followed by random runs of push and
// removal phases; every result is compared against its typed value or an
// in-bench stack model, with random idle input cycles and random output stalls.
// ----------------------------------------------------------------------------
module stack_with_extract_min_max_core_tb;
    import swemm_pkg::*;

    localparam int STACK_DEPTH  = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 40;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICTED    = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } stack_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        stack_result_t            want;
    } stack_row_t;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [MODE_W-1:0]          i_mode  = MODE_PUSH;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic                       i_stall = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [DATA_W-1:0]   o_result_value;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_count;

    // model of the stack contents, bottom entry at index 0
    logic signed [DATA_W-1:0]   stack_words [STACK_DEPTH];
    int                         stack_used = 0;

    stack_result_t              pending_results [$];
    stack_row_t                 directed_rows [$];
    bit                         calm = 1'b0;
    int                         errors = 0;
    int                         n_push = 0, n_full = 0, n_pop = 0;
    int                         n_min = 0, n_max = 0, n_empty = 0, n_checked = 0;

    stack_with_extract_min_max_core #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_count        (o_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 7);
    end

    function automatic stack_result_t apply_stack_op(input logic [MODE_W-1:0] mode,
                                                     input logic signed [DATA_W-1:0] value);
        stack_result_t            r;
        logic signed [DATA_W-1:0] pick;
        int                       kept;
        r.value  = '0;
        r.status = ST_OK;
        if (mode == MODE_PUSH) begin
            if (stack_used >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                stack_words[stack_used] = value;
                stack_used++;
            end
        end else if (stack_used == 0) begin
            r.status = ST_EMPTY;
        end else if (mode == MODE_POP) begin
            stack_used--;
            r.value = stack_words[stack_used];
        end else begin
            pick = stack_words[0];
            for (int i = 1; i < stack_used; i++) begin
                if (mode == MODE_EXT_MAX ? stack_words[i] > pick : stack_words[i] < pick)
                    pick = stack_words[i];
            end
            // drop every copy of the extreme, survivors keep their order
            kept = 0;
            for (int i = 0; i < stack_used; i++) begin
                if (stack_words[i] != pick) begin
                    stack_words[kept] = stack_words[i];
                    kept++;
                end
            end
            stack_used = kept;
            r.value = pick;
        end
        r.count = COUNT_W'(stack_used);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 8)
            return DATA_W'($urandom_range(0, 6)) - 32'sd3;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return '0;
        endcase
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
                           input bit typed, input logic signed [DATA_W-1:0] want_value,
                           input logic [STATUS_W-1:0] want_status,
                           input logic [COUNT_W-1:0] want_count);
        stack_row_t row;
        row.mode        = mode;
        row.value       = value;
        row.typed       = typed;
        row.want.value  = want_value;
        row.want.status = want_status;
        row.want.count  = want_count;
        directed_rows.push_back(row);
    endtask

    // offer one item, wait for it to be taken, then queue what it should produce
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
                             input bit typed, input stack_result_t want);
        bit            taken;
        stack_result_t predicted;
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        predicted = apply_stack_op(mode, value);
        pending_results.push_back(typed ? want : predicted);
        case (mode)
            MODE_PUSH:    n_push++;
            MODE_POP:     n_pop++;
            MODE_EXT_MIN: n_min++;
            default:      n_max++;
        endcase
        if (predicted.status == ST_FULL)  n_full++;
        if (predicted.status == ST_EMPTY) n_empty++;
    endtask

    // outputs are stable at the falling edge and taken at the next rising edge
    always @(negedge i_clk) begin
        stack_result_t got, want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.value  = o_result_value;
            got.status = o_status;
            got.count  = o_count;
            if (pending_results.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: value %0d status %0d count %0d",
                             got.value, got.status, got.count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.value !== want.value || got.status !== want.status
                    || got.count !== want.count) begin
                    if (errors < 10)
                        $display("mismatch on result %0d: value %0d/%0d status %0d/%0d %s%0d/%0d",
                                 n_checked, want.value, got.value, want.status, got.status,
                                 "count ", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        stack_result_t            none;
        logic [MODE_W-1:0]        mode;
        int                       push_pct;
        none = '0;

        // empty errors after reset, signed extremes, duplicates, full refusal
        add_row(MODE_POP,     32'sd0,       TYPED,     32'sd0, ST_EMPTY, 4'd0);
        add_row(MODE_EXT_MIN, -32'sd7,      TYPED,     32'sd0, ST_EMPTY, 4'd0);
        add_row(MODE_EXT_MAX, 32'h7fff_ffff, TYPED,    32'sd0, ST_EMPTY, 4'd0);
        add_row(MODE_PUSH,    32'h7fff_ffff, TYPED,    32'sd0, ST_OK,    4'd1);
        add_row(MODE_PUSH,    32'h8000_0000, TYPED,    32'sd0, ST_OK,    4'd2);
        add_row(MODE_PUSH,    -32'sd1,      TYPED,     32'sd0, ST_OK,    4'd3);
        add_row(MODE_PUSH,    32'sd0,       TYPED,     32'sd0, ST_OK,    4'd4);
        add_row(MODE_PUSH,    32'h8000_0000, TYPED,    32'sd0, ST_OK,    4'd5);
        add_row(MODE_PUSH,    32'h7fff_ffff, TYPED,    32'sd0, ST_OK,    4'd6);
        add_row(MODE_PUSH,    32'sd1,       TYPED,     32'sd0, ST_OK,    4'd7);
        add_row(MODE_PUSH,    32'sd5,       TYPED,     32'sd0, ST_OK,    4'd8);
        add_row(MODE_PUSH,    32'sd9,       TYPED,     32'sd0, ST_FULL,  4'd8);
        add_row(MODE_EXT_MIN, 32'sd0,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_EXT_MAX, 32'sd0,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_POP,     -32'sd1,      PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_EXT_MIN, 32'sd0,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_PUSH,    32'sd1,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_EXT_MAX, 32'sd0,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_POP,     32'sd0,       PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_POP,     32'sd0,       TYPED,     32'sd0, ST_EMPTY, 4'd0);
        add_row(MODE_PUSH,    -32'sd5,      PREDICTED, 32'sd0, ST_OK,    4'd0);
        add_row(MODE_EXT_MAX, 32'sd3,       PREDICTED, 32'sd0, ST_OK,    4'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].mode, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].want);

        // phases lean toward filling or draining so both ends get exercised
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            calm = (n >= 200 && n < 300);
            if ($urandom_range(0, 99) < push_pct) begin
                mode = MODE_PUSH;
            end else begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_POP;
                    1:       mode = MODE_EXT_MIN;
                    default: mode = MODE_EXT_MAX;
                endcase
            end
            send_item(mode, pick_word(), PREDICTED, none);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items: %0d push (%0d refused full), %0d pop, %0d extract min, %0d extract max",
                 n_push, n_full, n_pop, n_min, n_max);
        $display("%0d removals hit an empty stack, %0d results checked, %0d errors",
                 n_empty, n_checked, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
design/swemm_pkg.sv
design/stack_with_extract_min_max_core.sv
tb/stack_with_extract_min_max_core_tb.sv
